/* sv/assert_macros.svh */
// assertion macros shared by the led event priority select rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define LEP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");
// next-cycle implication
`define LEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`else
`define LEP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LEP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/lep_pkg.sv */
// types and constants of the led event priority select block
package lep_pkg;

	typedef logic [3:0] nibble_t;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_COMMIT = 1'b1;

	localparam nibble_t PRIO_NONE = 4'd0;

	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_EVENT_COUNT    = 3'd0,
		CFG_EDGE_MASK      = 3'd1,
		CFG_PRIORITY_TABLE = 3'd2,
		CFG_DISPLAY_TABLE  = 3'd3,
		CFG_DEVICE_ID      = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic       kind;
		logic [2:0] event_index;
		logic       port;
		logic       active;
	} in_item_t;

	typedef struct packed {
		logic [7:0] device;
		logic       out_port;
		nibble_t    display_type;
		logic       changed;
	} out_item_t;

	// item held in the input register
	typedef struct packed {
		logic     valid;
		in_item_t item;
	} stage_t;

endpackage

/* sv/lep_in_stage.sv */
// input register stage with stall back to the sample channel
module lep_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	input  lep_pkg::in_item_t sample,
	input  logic              go,
	output logic              sample_stall,
	output lep_pkg::stage_t   s1
);

	logic              valid_s1;
	lep_pkg::in_item_t item_s1;
	logic              accept;

	assign sample_stall = valid_s1 && !go;
	assign accept       = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= sample;
		end
	end

	assign s1.valid = valid_s1;
	assign s1.item  = item_s1;

endmodule

/* sv/lep_select.sv */
// configuration registers, per-port priority state and result selection
`include "assert_macros.svh"

module lep_select #(
	parameter int EVENTS = 8,
	parameter int PORTS  = 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [lep_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [lep_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  lep_pkg::stage_t                    s1,
	input  logic                               go,
	output logic                               res_req,
	output lep_pkg::out_item_t                 res_item
);

	localparam int EW = (EVENTS > 1) ? $clog2(EVENTS) : 1;
	localparam int PW = (PORTS > 1) ? $clog2(PORTS) : 1;
	localparam logic [3:0] EVENTS_L = 4'(EVENTS);
	localparam logic [3:0] PORTS_L  = 4'(PORTS);

	logic [3:0]       event_count_q;
	logic [7:0]       edge_mask_q;
	logic [31:0]      prio_tab_q;
	logic [31:0]      disp_tab_q;
	logic [7:0]       device_q;

	logic [EVENTS-1:0] prev_q        [PORTS];
	lep_pkg::nibble_t  best_prio_q   [PORTS];
	lep_pkg::nibble_t  best_disp_q   [PORTS];
	lep_pkg::nibble_t  committed_q   [PORTS];

	logic [PW-1:0]     pidx;
	logic [EW-1:0]     eidx;
	logic [2:0]        idx;
	logic              port_ok;
	logic              slot_ok;
	logic              is_sample;
	logic              is_commit;
	logic              sample_ok;
	logic              commit_ok;
	logic              edge_evt;
	logic              evt_valid;
	lep_pkg::nibble_t  prio_nib;
	lep_pkg::nibble_t  disp_nib;
	logic              win;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_count_q <= '0;
			edge_mask_q   <= '0;
			prio_tab_q    <= '0;
			disp_tab_q    <= '0;
			device_q      <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				lep_pkg::CFG_EVENT_COUNT:    event_count_q <= cfg_data[3:0];
				lep_pkg::CFG_EDGE_MASK:      edge_mask_q   <= cfg_data[7:0];
				lep_pkg::CFG_PRIORITY_TABLE: prio_tab_q    <= cfg_data[31:0];
				lep_pkg::CFG_DISPLAY_TABLE:  disp_tab_q    <= cfg_data[31:0];
				lep_pkg::CFG_DEVICE_ID:      device_q      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign idx       = s1.item.event_index;
	assign pidx      = PW'(s1.item.port);
	assign eidx      = EW'(idx);
	assign port_ok   = 4'(s1.item.port) < PORTS_L;
	// slots beyond the count in use or the built storage are ignored
	assign slot_ok   = ({1'b0, idx} < event_count_q) && ({1'b0, idx} < EVENTS_L);
	assign is_sample = s1.valid && (s1.item.kind == lep_pkg::KIND_SAMPLE);
	assign is_commit = s1.valid && (s1.item.kind == lep_pkg::KIND_COMMIT);
	assign sample_ok = is_sample && port_ok && slot_ok;
	assign commit_ok = is_commit && port_ok;

	assign edge_evt  = edge_mask_q[idx];
	assign evt_valid = s1.item.active && (!edge_evt || !prev_q[pidx][eidx]);
	assign prio_nib  = prio_tab_q[{idx, 2'b00} +: 4];
	assign disp_nib  = disp_tab_q[{idx, 2'b00} +: 4];
	// strict compare: ties keep the earlier winner, priority zero never wins
	assign win       = sample_ok && evt_valid && (prio_nib > best_prio_q[pidx]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PORTS; p++) begin
				prev_q[p]      <= '0;
				best_prio_q[p] <= lep_pkg::PRIO_NONE;
				best_disp_q[p] <= '0;
				committed_q[p] <= '0;
			end
		end else if (go) begin
			if (sample_ok) begin
				prev_q[pidx][eidx] <= s1.item.active;
			end
			if (win) begin
				best_prio_q[pidx] <= prio_nib;
				best_disp_q[pidx] <= disp_nib;
			end
			if (commit_ok) begin
				committed_q[pidx] <= best_disp_q[pidx];
				best_prio_q[pidx] <= lep_pkg::PRIO_NONE;
			end
		end
	end

	assign res_req               = commit_ok;
	assign res_item.device       = device_q;
	assign res_item.out_port     = s1.item.port;
	assign res_item.display_type = best_disp_q[pidx];
	assign res_item.changed      = committed_q[pidx] != best_disp_q[pidx];

	`LEP_ASSERT_NEXT(a_commit_clears_prio, clk, arst_n, go && commit_ok, best_prio_q[$past(pidx)] == lep_pkg::PRIO_NONE)
	`LEP_ASSERT_NEXT(a_win_sets_prio, clk, arst_n, go && win, best_prio_q[$past(pidx)] != lep_pkg::PRIO_NONE)

endmodule

/* sv/lep_out_reg.sv */
// result register that frees the pipeline from the result channel
module lep_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  lep_pkg::out_item_t item,
	input  logic               result_stall,
	output logic               result_valid,
	output lep_pkg::out_item_t result,
	output logic               free
);

	logic               valid_s2;
	lep_pkg::out_item_t item_s2;

	assign free = !valid_s2 || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s2 <= item;
		end
	end

	assign result_valid = valid_s2;
	assign result       = item_s2;

endmodule

/* sv/led_event_priority_select.sv */
// Picks an LED display pattern per port from a stream of prioritised event samples.
// Sample channel: sample_valid/sample_stall with one sample beat per item; a beat
// either reports one event slot's active bit for a port or commits a port.
// Result channel: result_valid/result_stall; each commit of a present port
// yields one result beat with device number, port, display type and changed flag.
// Samples yield no result. A beat is moved when valid is high and stall is low.
// A commit passes the input register and then the result register.
// Throughput: one item per cycle unless stalled; the input and result registers run
// back to back, every decision being one nibble compare against the port's best.
// Configuration: cfg_write with cfg_index and cfg_data writes one register per cycle;
// the user makes writes only while no item is in flight; not enforced by the block.
// When the receiver stalls, the result register holds its beat; samples keep
// flowing, and only a commit sitting in the input register while the result
// register is full stalls the sample channel.
// Reset clears the configuration, the edge history and all per-port state.
`include "assert_macros.svh"

module led_event_priority_select #(
	parameter int EVENTS = 8,
	parameter int PORTS  = 2
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [lep_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lep_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  lep_pkg::in_item_t               sample,
	output logic                            result_valid,
	input  logic                            result_stall,
	output lep_pkg::out_item_t              result
);

	lep_pkg::stage_t    s1;
	logic               go;
	logic               res_req;
	logic               free;
	logic               res_fire;
	lep_pkg::out_item_t res_item;

	// the input register empties unless its commit finds the result register full and stalled
	assign go       = s1.valid && (!res_req || free);
	assign res_fire = go && res_req;

	lep_in_stage u_in (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample       (sample),
		.go           (go),
		.sample_stall (sample_stall),
		.s1           (s1)
	);

	lep_select #(
		.EVENTS (EVENTS),
		.PORTS  (PORTS)
	) u_sel (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s1        (s1),
		.go        (go),
		.res_req   (res_req),
		.res_item  (res_item)
	);

	lep_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (res_fire),
		.item         (res_item),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.free         (free)
	);

	`LEP_ASSERT_NOW(a_stall_only_on_full, clk, arst_n, sample_stall, res_req && result_valid && result_stall)
	`LEP_ASSERT_NEXT(a_fire_shows_result, clk, arst_n, res_fire, result_valid)
	`LEP_ASSERT_NEXT(a_taken_without_refill, clk, arst_n, result_valid && !result_stall && !res_fire, !result_valid)

endmodule
